FILE: hw/rtl/cseq_pkg.sv
// Shared types and constants of the cursor sequence store.
package cseq_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_START   = 3'd0,
		OP_ADVANCE = 3'd1,
		OP_INSERT  = 3'd2,
		OP_ATTACH  = 3'd3,
		OP_REMOVE  = 3'd4,
		OP_QUERY   = 3'd5
	} op_e;

	typedef enum logic [1:0] {
		SH_NONE  = 2'd0,
		SH_OPEN  = 2'd1,
		SH_CLOSE = 2'd2
	} shift_e;

	// Command from the controller to the datapath for one accepted item.
	typedef struct packed {
		logic   capture;
		shift_e shift;
		logic   take_value;
		logic   cur_valid;
	} dp_cmd_t;

endpackage

FILE: hw/rtl/cseq_req_if.sv
// Request channel: one operation and its value per item.
interface cseq_req_if;
	logic                         valid;
	logic                         ready;
	logic [cseq_pkg::OP_W-1:0]    op;
	logic [cseq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

FILE: hw/rtl/cseq_rsp_if.sv
// Response channel: store status after each operation.
interface cseq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [cseq_pkg::COUNT_W-1:0] count;
	logic                         has_current;
	logic [cseq_pkg::VALUE_W-1:0] current_value;
	logic                         error;

	modport source (output valid, output count, output has_current, output current_value,
		output error, input ready);
	modport sink (input valid, input count, input has_current, input current_value,
		input error, output ready);
endinterface

FILE: hw/rtl/cseq_datapath.sv
// Entry register array with shift network and the current value result register.
module cseq_datapath #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic [cseq_pkg::VALUE_W-1:0] value,
	input  cseq_pkg::dp_cmd_t            cmd,
	input  logic [$clog2(CAPACITY)-1:0]  gap_pos,
	input  logic [$clog2(CAPACITY)-1:0]  rd_pos,
	output logic [cseq_pkg::VALUE_W-1:0] current_value
);

	localparam int AW = $clog2(CAPACITY);
	localparam int VW = cseq_pkg::VALUE_W;
	localparam int SW = (DATA_WIDTH < VW) ? DATA_WIDTH : VW;

	logic [SW-1:0] entries_q [CAPACITY];
	logic [SW-1:0] wdata;
	logic [SW-1:0] rd_data;
	logic [VW-1:0] cur_q;

	assign wdata   = SW'(value);
	assign rd_data = entries_q[rd_pos];

	// Every position moves at once: an open shifts the tail up by one and
	// writes the gap, a close pulls the tail down over the removed entry.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			unique case (cmd.shift)
				cseq_pkg::SH_OPEN: begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (gap_pos == AW'(i)) begin
							entries_q[i] <= wdata;
						end else if (gap_pos < AW'(i)) begin
							entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
						end
					end
				end
				cseq_pkg::SH_CLOSE: begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (gap_pos <= AW'(i) && i < CAPACITY - 1) begin
							entries_q[i] <= entries_q[(i < CAPACITY - 1) ? i + 1 : i];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The read uses the array before the operation; the controller picks the
	// address that holds the entry which is current afterwards.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (!cmd.cur_valid) begin
				cur_q <= '0;
			end else if (cmd.take_value) begin
				cur_q <= VW'(wdata);
			end else begin
				cur_q <= VW'(rd_data);
			end
		end
	end

	assign current_value = cur_q;

endmodule

FILE: hw/rtl/cseq_ctrl.sv
// Controller: operation decode, cursor and count state, result handshake.
module cseq_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [cseq_pkg::OP_W-1:0]    op,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [cseq_pkg::COUNT_W-1:0] count,
	output logic                         has_current,
	output logic                         error,
	output cseq_pkg::dp_cmd_t            cmd,
	output logic [$clog2(CAPACITY)-1:0]  gap_pos,
	output logic [$clog2(CAPACITY)-1:0]  rd_pos
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [0:0] {
		ST_EMPTY = 1'b0,
		ST_HOLD  = 1'b1
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic          valid_q;
	logic          err_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] pos_inc;
	logic [CW-1:0] nxt_count;
	logic [AW-1:0] nxt_pos;
	logic          nxt_valid;
	logic          err_c;
	logic [AW-1:0] gap_c;
	logic [AW-1:0] rd_c;
	cseq_pkg::shift_e shift_c;
	logic          take_c;

	assign req_ready = (state_q == ST_EMPTY) || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = count_q >= CW'(CAPACITY);
	assign pos_inc   = CW'(pos_q) + CW'(1);

	always_comb begin
		nxt_count = count_q;
		nxt_pos   = pos_q;
		nxt_valid = valid_q;
		err_c     = 1'b0;
		gap_c     = pos_q;
		rd_c      = pos_q;
		shift_c   = cseq_pkg::SH_NONE;
		take_c    = 1'b0;
		unique case (cseq_pkg::op_e'(op))
			cseq_pkg::OP_START: begin
				nxt_pos   = '0;
				nxt_valid = count_q != '0;
				rd_c      = '0;
			end
			cseq_pkg::OP_ADVANCE: begin
				if (!valid_q) begin
					err_c = 1'b1;
				end else if (pos_inc >= count_q) begin
					nxt_pos   = '0;
					nxt_valid = 1'b0;
				end else begin
					nxt_pos = AW'(pos_inc);
					rd_c    = AW'(pos_inc);
				end
			end
			cseq_pkg::OP_INSERT, cseq_pkg::OP_ATTACH: begin
				if (full) begin
					err_c = 1'b1;
				end else begin
					if (cseq_pkg::op_e'(op) == cseq_pkg::OP_INSERT) begin
						gap_c = valid_q ? pos_q : '0;
					end else begin
						gap_c = valid_q ? AW'(pos_inc) : AW'(count_q);
					end
					shift_c   = cseq_pkg::SH_OPEN;
					take_c    = 1'b1;
					nxt_pos   = gap_c;
					nxt_valid = 1'b1;
					nxt_count = count_q + CW'(1);
				end
			end
			cseq_pkg::OP_REMOVE: begin
				if (!valid_q) begin
					err_c = 1'b1;
				end else begin
					shift_c   = cseq_pkg::SH_CLOSE;
					rd_c      = AW'(pos_inc);
					nxt_count = count_q - CW'(1);
					if (pos_inc >= count_q) begin
						nxt_pos   = '0;
						nxt_valid = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.capture    = accept;
	assign cmd.shift      = accept ? shift_c : cseq_pkg::SH_NONE;
	assign cmd.take_value = take_c;
	assign cmd.cur_valid  = nxt_valid;
	assign gap_pos        = gap_c;
	assign rd_pos         = rd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
			count_q <= '0;
			pos_q   <= '0;
			valid_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_HOLD;
				count_q <= nxt_count;
				pos_q   <= nxt_pos;
				valid_q <= nxt_valid;
				err_q   <= err_c;
			end else if (rsp_ready) begin
				state_q <= ST_EMPTY;
			end
		end
	end

	assign rsp_valid   = state_q == ST_HOLD;
	assign count       = cseq_pkg::COUNT_W'(count_q);
	assign has_current = valid_q;
	assign error       = err_q;

	a_cursor_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (CW'(pos_q) < count_q))
		else $error("cursor points beyond the stored entries");

	a_refused_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_c) |=> (count_q == $past(count_q) && pos_q == $past(pos_q)
			&& valid_q == $past(valid_q)))
		else $error("refused operation changed the store");

	a_open_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && shift_c == cseq_pkg::SH_OPEN) |=>
			(count_q == $past(count_q) + CW'(1) && valid_q))
		else $error("insert did not add a current entry");

	a_close_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && shift_c == cseq_pkg::SH_CLOSE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not drop one entry");

endmodule

FILE: hw/rtl/cursor_sequence_store.sv
// The result of an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle while rsp.ready is high; the whole entry array shifts in
// the accepting cycle, and the result registers refill in the cycle the result is taken.
// Reset (arst_n low, asynchronous): the store is empty with no current entry and no result
// pending; entry data is not cleared, since entries beyond the count are never read.
// Top level: ordered store of up to CAPACITY values with a cursor.
module cursor_sequence_store #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	cseq_req_if.sink  req,
	cseq_rsp_if.source rsp
);

	// Command and cursor addresses flowing from the controller to the datapath.
	cseq_pkg::dp_cmd_t             cmd;
	logic [$clog2(CAPACITY)-1:0]   gap_pos;
	logic [$clog2(CAPACITY)-1:0]   rd_pos;

	// The controller owns the count, the cursor and the handshake. It decides,
	// for each accepted item, whether the array opens a gap, closes one, or
	// stays, and which old position holds the entry that becomes current.
	cseq_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.op          (req.op),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.count       (rsp.count),
		.has_current (rsp.has_current),
		.error       (rsp.error),
		.cmd         (cmd),
		.gap_pos     (gap_pos),
		.rd_pos      (rd_pos)
	);

	// The datapath holds the entries as a register array that moves every
	// position at once, and registers the current value for the result.
	cseq_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.value         (req.value),
		.cmd           (cmd),
		.gap_pos       (gap_pos),
		.rd_pos        (rd_pos),
		.current_value (rsp.current_value)
	);

endmodule
